// ===== rtl/substring_first_match_defines.svh =====
// Assertion macros used by the checker file of the substring search block.
`ifndef SUBSTRING_FIRST_MATCH_DEFINES_SVH
`define SUBSTRING_FIRST_MATCH_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define SFM_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define SFM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sfm_pkg.sv =====
`timescale 1ns / 1ps
package sfm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int TEXT_LIMIT  = 65536;
    localparam int QUEUE_DEPTH = 2;

    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int CNT_W  = $clog2(TEXT_LIMIT + 2);
    localparam int POS_W  = 16;
    localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] t_status;

    localparam t_status STATUS_OK        = 2'd0;
    localparam t_status STATUS_EMPTY     = 2'd1;
    localparam t_status STATUS_PAT_LONG  = 2'd2;
    localparam t_status STATUS_TEXT_OVER = 2'd3;

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    // One classified entry of the front queue.
    typedef struct packed {
        logic       is_text;
        logic [7:0] data;
        logic       is_final;
    } t_item;

    // Head of the front queue as seen by the back end.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

endpackage

// ===== rtl/sfm_front.sv =====
`timescale 1ns / 1ps
module sfm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_cmd,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_is_final,
    input  logic                 i_pop,
    output sfm_pkg::t_queue_head o_head
);
    import sfm_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count,  n_count;
    logic                push;
    logic                pop;
    t_item               in_item;

    // Classify the incoming transaction.
    assign in_item.is_text  = (i_cmd == CMD_TEXT);
    assign in_item.data     = i_data_byte;
    assign in_item.is_final = i_is_final;

    assign o_ready = i_rst_n && (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        begin
            if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
                r = '0;
            end else begin
                r = p + 1'b1;
            end
            return r;
        end
    endfunction

    always_comb begin
        n_wr_ptr = push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

endmodule

// ===== rtl/sfm_back.sv =====
`timescale 1ns / 1ps
module sfm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfm_pkg::t_queue_head i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_found,
    output logic [15:0]          o_match_start,
    output logic [1:0]           o_status
);
    import sfm_pkg::*;

    // Pattern is held newest-first so it lines up with the text window.
    logic [7:0]        r_pat [PATTERN_MAX];
    logic [7:0]        r_win [PATTERN_MAX];
    logic [LEN_W-1:0]  r_pat_len,  n_pat_len;
    logic              r_pat_ovf,  n_pat_ovf;
    logic              r_pat_done, n_pat_done;
    logic [CNT_W-1:0]  r_count,    n_count;
    logic              r_hit,      n_hit;
    logic [POS_W-1:0]  r_hit_pos,  n_hit_pos;
    logic              r_out_valid;
    logic              r_out_found;
    logic [POS_W-1:0]  r_out_start;
    t_status           r_out_status;

    logic              pat_shift;
    logic              win_shift;
    logic              emit;
    logic [LEN_W-1:0]  len_base;
    logic [PATTERN_MAX-1:0] eq;
    logic              match;
    logic [CMP_W-1:0]  pos_inc;
    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  start_pos;
    t_status           status;
    logic              found;
    logic [POS_W-1:0]  out_start;

    assign o_pop = i_head.valid && (!r_out_valid || i_ready);

    // Compare each window lane against its pattern lane; lanes past the length pass.
    always_comb begin
        eq[0] = (r_pat_len == '0) || (i_head.item.data == r_pat[0]);
        for (int j = 1; j < PATTERN_MAX; j++) begin
            eq[j] = (r_pat_len <= LEN_W'(j)) || (r_win[j-1] == r_pat[j]);
        end
    end
    assign match = &eq;

    assign pos_inc   = CMP_W'(r_count) + 1'b1;
    assign len_ext   = CMP_W'(r_pat_len);
    assign start_pos = pos_inc - len_ext;

    always_comb begin
        n_pat_len  = r_pat_len;
        n_pat_ovf  = r_pat_ovf;
        n_pat_done = r_pat_done;
        n_count    = r_count;
        n_hit      = r_hit;
        n_hit_pos  = r_hit_pos;
        pat_shift  = 1'b0;
        win_shift  = 1'b0;
        emit       = 1'b0;
        len_base   = r_pat_done ? '0 : r_pat_len;
        status     = STATUS_OK;
        found      = 1'b0;
        out_start  = '0;

        if (o_pop && !i_head.item.is_text) begin
            // Restart the pattern when the previous one was finished.
            if (r_pat_done) begin
                n_pat_ovf = 1'b0;
            end
            if (len_base < LEN_W'(PATTERN_MAX)) begin
                pat_shift = 1'b1;
                n_pat_len = len_base + 1'b1;
            end else begin
                n_pat_len = len_base;
                n_pat_ovf = 1'b1;
            end
            n_pat_done = i_head.item.is_final;
        end else if (o_pop) begin
            if (r_count < CNT_W'(TEXT_LIMIT)) begin
                win_shift = 1'b1;
                n_count   = r_count + 1'b1;
                if (!r_hit && !r_pat_ovf && (r_pat_len != '0) &&
                    (pos_inc >= len_ext) && match) begin
                    n_hit     = 1'b1;
                    n_hit_pos = POS_W'(start_pos);
                end
            end else begin
                n_count = CNT_W'(TEXT_LIMIT + 1);
            end

            if (i_head.item.is_final) begin
                emit = 1'b1;
                if (r_pat_ovf) begin
                    status = STATUS_PAT_LONG;
                end else if (r_pat_len == '0) begin
                    status = STATUS_EMPTY;
                end else if (n_count > CNT_W'(TEXT_LIMIT)) begin
                    status = STATUS_TEXT_OVER;
                end else begin
                    status = STATUS_OK;
                end
                found     = n_hit && ((status == STATUS_OK) || (status == STATUS_TEXT_OVER));
                out_start = found ? n_hit_pos : '0;
                // Clear text state for the next text.
                n_count   = '0;
                n_hit     = 1'b0;
                n_hit_pos = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len   <= '0;
            r_pat_ovf   <= 1'b0;
            r_pat_done  <= 1'b0;
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_hit_pos   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pat_len  <= n_pat_len;
            r_pat_ovf  <= n_pat_ovf;
            r_pat_done <= n_pat_done;
            r_count    <= n_count;
            r_hit      <= n_hit;
            r_hit_pos  <= n_hit_pos;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pat_shift) begin
            r_pat[0] <= i_head.item.data;
            for (int j = 1; j < PATTERN_MAX; j++) begin
                r_pat[j] <= r_pat[j-1];
            end
        end
        if (win_shift) begin
            r_win[0] <= i_head.item.data;
            for (int j = 1; j < PATTERN_MAX; j++) begin
                r_win[j] <= r_win[j-1];
            end
        end
        if (emit) begin
            r_out_found  <= found;
            r_out_start  <= out_start;
            r_out_status <= status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_found       = r_out_found;
    assign o_match_start = r_out_start;
    assign o_status      = r_out_status;

endmodule

// ===== rtl/substring_first_match.sv =====
`timescale 1ns / 1ps
// Exact substring search, first occurrence. Load the pattern with cmd 0 bytes
// (mark the last with is_final), then stream the text with cmd 1 bytes; the text
// byte that carries is_final yields one result: found, the start position of the
// earliest match (low 16 bits, 0 when not found) and a status (ok, empty pattern,
// pattern longer than 32 bytes, text beyond 65536 bytes). The pattern stays loaded
// for the next text. Throughput is one byte per cycle: a two-entry input queue
// feeds a back end that shifts each text byte into a 32-byte window and compares
// all lanes against the pattern in the same cycle. Accepted input is written
// into the queue and each result is registered. The back end only stalls while
// the single output register holds a result that has not been taken; the queue
// keeps accepting meanwhile until it fills.
module substring_first_match (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_final,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [15:0] o_match_start,
    output logic [1:0]  o_status
);
    import sfm_pkg::*;

    t_queue_head head;
    logic        pop;

    // Front: accept and classify each transaction into the queue.
    sfm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_data_byte (i_data_byte),
        .i_is_final  (i_is_final),
        .i_pop       (pop),
        .o_head      (head)
    );

    // Back: hold pattern and window, compare, latch the first hit, emit the result.
    sfm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found       (o_found),
        .o_match_start (o_match_start),
        .o_status      (o_status)
    );

endmodule

// ===== rtl/sfm_checker.sv =====
`timescale 1ns / 1ps
`include "substring_first_match_defines.svh"
module sfm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_cmd,
    input logic [7:0]  i_data_byte,
    input logic        i_is_final,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_found,
    input logic [15:0] o_match_start,
    input logic [1:0]  o_status
);
    import sfm_pkg::*;

    `SFM_ASSERT_CLK(a_start_zero, i_clk, i_rst_n, o_valid && !o_found |-> o_match_start == '0, "match_start nonzero without a hit")
    `SFM_ASSERT_CLK(a_found_status, i_clk, i_rst_n, o_valid && o_found |-> (o_status == STATUS_OK) || (o_status == STATUS_TEXT_OVER), "hit reported with error status")
    `SFM_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_found) && $stable(o_match_start) && $stable(o_status), "result dropped or changed while stalled")
    `SFM_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid, "result valid right after reset")

endmodule

bind substring_first_match sfm_checker u_sfm_checker (.*);
